// File: src/dwid_pkg.sv
// ----------------------------------------------------------------------------
// dwid_pkg
// Shared types and constants for the deque with indexed delete.
// ----------------------------------------------------------------------------
package dwid_pkg;

  localparam int CMD_W        = 2;
  localparam int VAL_W        = 30;
  localparam int DEF_CAPACITY = 32;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_LIST_FWD,
    ST_LIST_REV,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic pass_dir;
    logic list_empty;
    logic insert_refused;
    logic last;
  } meta_t;

  typedef struct packed {
    logic  load;
    meta_t meta;
  } out_req_t;

endpackage

// File: src/dwid_in_if.sv
// ----------------------------------------------------------------------------
// dwid_in_if
// Command channel: valid/ready handshake with command code and operand.
// ----------------------------------------------------------------------------
interface dwid_in_if;
  logic                          valid;
  logic                          ready;
  logic [dwid_pkg::CMD_W-1:0]    cmd;
  logic [dwid_pkg::VAL_W-1:0]    operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

// File: src/dwid_out_if.sv
// ----------------------------------------------------------------------------
// dwid_out_if
// Result channel: valid/ready handshake with one listing entry per transfer.
// ----------------------------------------------------------------------------
interface dwid_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pass_dir;
  logic [dwid_pkg::VAL_W-1:0]    element;
  logic                          list_empty;
  logic                          insert_refused;
  logic                          last;

  modport source (output valid, output pass_dir, output element, output list_empty,
                  output insert_refused, output last, input ready);
  modport sink   (input valid, input pass_dir, input element, input list_empty,
                  input insert_refused, input last, output ready);
endinterface

// File: src/dwid_mem.sv
// ----------------------------------------------------------------------------
// dwid_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dwid_mem #(
  parameter int DEPTH = dwid_pkg::DEF_CAPACITY,
  parameter int WIDTH = dwid_pkg::VAL_W,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/dwid_out_stage.sv
// ----------------------------------------------------------------------------
// dwid_out_stage
// Result register: holds one listing entry until the sink takes it.
// ----------------------------------------------------------------------------
module dwid_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dwid_pkg::out_req_t         req,
  input  logic [dwid_pkg::VAL_W-1:0] rdata,
  output logic                       out_free,
  dwid_out_if.source                 out_chan
);

  logic                       valid_r;
  logic                       valid_nxt;
  dwid_pkg::meta_t            meta_r;
  logic [dwid_pkg::VAL_W-1:0] element_r;

  assign out_free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (req.load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      meta_r    <= req.meta;
      element_r <= req.meta.list_empty ? '0 : rdata;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.pass_dir       = meta_r.pass_dir;
  assign out_chan.element        = element_r;
  assign out_chan.list_empty     = meta_r.list_empty;
  assign out_chan.insert_refused = meta_r.insert_refused;
  assign out_chan.last           = meta_r.last;

endmodule

// File: src/dwid_ctrl.sv
// ----------------------------------------------------------------------------
// dwid_ctrl
// Command sequencer: ring pointers, shared slot adder, shift and listing.
// ----------------------------------------------------------------------------
module dwid_ctrl #(
  parameter int CAPACITY = dwid_pkg::DEF_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dwid_in_if.sink                    in_chan,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [dwid_pkg::VAL_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [dwid_pkg::VAL_W-1:0] mem_rdata,
  input  logic                       out_free,
  output dwid_pkg::out_req_t         out_req
);

  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [AW-1:0] HEAD_MAX = AW'(CAPACITY - 1);

  dwid_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             refused_r, refused_nxt;
  logic             pend_r, pend_nxt;
  dwid_pkg::meta_t  meta_r, meta_nxt;

  logic             in_xfer;
  logic             issue_ok;
  logic             full;
  logic [AW-1:0]    head_dec;
  logic [CW-1:0]    pos_p1;
  logic [CW-1:0]    pos_in;
  logic [CW:0]      slot_sum;
  logic [CW:0]      slot_red;
  logic [AW-1:0]    slot;

  assign in_chan.ready = (state_r == dwid_pkg::ST_IDLE) && !pend_r;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign issue_ok      = !pend_r || out_free;
  assign full          = (count_r >= CAP_C);
  assign head_dec      = (head_r == '0) ? HEAD_MAX : head_r - AW'(1);
  assign pos_p1        = pos_r + CW'(1);

  // shared slot unit: (head + position) mod CAPACITY
  assign pos_in   = (state_r == dwid_pkg::ST_IDLE)     ? count_r :
                    (state_r == dwid_pkg::ST_SHIFT_RD) ? pos_p1  : pos_r;
  assign slot_sum = (CW+1)'(head_r) + (CW+1)'(pos_in);
  assign slot_red = (slot_sum >= (CW+1)'(CAPACITY)) ? slot_sum - (CW+1)'(CAPACITY)
                                                    : slot_sum;
  assign slot     = slot_red[AW-1:0];

  assign out_req.load = pend_r && out_free;
  assign out_req.meta = meta_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    refused_nxt = refused_r;
    pend_nxt    = (pend_r && out_free) ? 1'b0 : pend_r;
    meta_nxt    = meta_r;
    mem_we      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = in_chan.operand;
    mem_re      = 1'b0;
    mem_raddr   = slot;
    case (state_r)
      dwid_pkg::ST_IDLE: begin
        if (in_xfer) begin
          refused_nxt = 1'b0;
          pos_nxt     = '0;
          state_nxt   = dwid_pkg::ST_LIST_FWD;
          case (in_chan.cmd)
            dwid_pkg::CMD_INS_HEAD: begin
              if (full) begin
                refused_nxt = 1'b1;
              end else begin
                head_nxt  = head_dec;
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            dwid_pkg::CMD_INS_TAIL: begin
              if (full) begin
                refused_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            dwid_pkg::CMD_DELETE: begin
              if (dwid_pkg::VAL_W'(count_r) > in_chan.operand) begin
                pos_nxt   = in_chan.operand[CW-1:0];
                state_nxt = dwid_pkg::ST_SHIFT_RD;
              end
            end
            default: begin
            end
          endcase
          if (state_nxt == dwid_pkg::ST_LIST_FWD && count_nxt == '0) begin
            state_nxt = dwid_pkg::ST_EMPTY;
          end
        end
      end
      dwid_pkg::ST_SHIFT_RD: begin
        if (pos_p1 < count_r) begin
          mem_re    = 1'b1;
          state_nxt = dwid_pkg::ST_SHIFT_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          pos_nxt   = '0;
          state_nxt = (count_r == CW'(1)) ? dwid_pkg::ST_EMPTY : dwid_pkg::ST_LIST_FWD;
        end
      end
      dwid_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        pos_nxt   = pos_p1;
        state_nxt = dwid_pkg::ST_SHIFT_RD;
      end
      dwid_pkg::ST_LIST_FWD: begin
        if (issue_ok) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          meta_nxt = '{pass_dir: 1'b0, list_empty: 1'b0,
                       insert_refused: refused_r, last: 1'b0};
          if (pos_p1 == count_r) begin
            state_nxt = dwid_pkg::ST_LIST_REV;
          end else begin
            pos_nxt = pos_p1;
          end
        end
      end
      dwid_pkg::ST_LIST_REV: begin
        if (issue_ok) begin
          mem_re   = 1'b1;
          pend_nxt = 1'b1;
          meta_nxt = '{pass_dir: 1'b1, list_empty: 1'b0,
                       insert_refused: refused_r, last: (pos_r == '0)};
          if (pos_r == '0) begin
            state_nxt = dwid_pkg::ST_IDLE;
          end else begin
            pos_nxt = pos_r - CW'(1);
          end
        end
      end
      dwid_pkg::ST_EMPTY: begin
        if (issue_ok) begin
          pend_nxt  = 1'b1;
          meta_nxt  = '{pass_dir: 1'b0, list_empty: 1'b1,
                        insert_refused: refused_r, last: 1'b1};
          state_nxt = dwid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dwid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dwid_pkg::ST_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      pos_r     <= '0;
      refused_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      refused_r <= refused_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meta_r <= meta_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HEAD_MAX)
    else $error("head slot out of ring");

  a_no_write_in_listing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwid_pkg::ST_LIST_FWD || state_r == dwid_pkg::ST_LIST_REV) |-> !mem_we)
    else $error("store written during listing");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dwid_pkg::ST_SHIFT_RD && !(pos_p1 < count_r))
      |=> count_r == $past(count_r) - CW'(1))
    else $error("delete did not shrink list");

endmodule

// File: src/deque_with_indexed_delete.sv
// ----------------------------------------------------------------------------
// deque_with_indexed_delete
// Bounded ring list with head/tail insert and indexed delete; lists the
// whole list forward then backward after every command.
// ----------------------------------------------------------------------------
// The first result passes the listing state, the store read and pending registers and the
//   result register, later by the delete shift. Throughput: one result per cycle while
//   listing and out_chan is ready; a command leaving n entries gives 2*n results (one when
//   the list ends empty); a hitting delete first moves each later entry by a read and a write.
// Reset: rst_n clears pointers, count and handshake state; store contents
//   stay undefined and are never read before being written.
module deque_with_indexed_delete #(
  parameter int CAPACITY = dwid_pkg::DEF_CAPACITY
) (
  input logic        clk,
  input logic        rst_n,
  dwid_in_if.sink    in_chan,
  dwid_out_if.source out_chan
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [dwid_pkg::VAL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [dwid_pkg::VAL_W-1:0] mem_rdata;
  logic                       out_free;
  dwid_pkg::out_req_t         out_req;

  dwid_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .out_req   (out_req)
  );

  dwid_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (dwid_pkg::VAL_W),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dwid_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (out_req),
    .rdata    (mem_rdata),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule
